[rtl/lcd2_pkg.sv]
// shared types, constants and register indexes for the two-line lcd character writer
// no dependencies
package lcd2_pkg;

    localparam int LINE_CHARS = 16;
    localparam int MAX_CHARS  = 32;
    localparam int MAX_XFERS  = 4;
    localparam int CHAR_IDX_W = $clog2(MAX_CHARS + 1);
    localparam int XFER_CNT_W = $clog2(MAX_XFERS + 1);
    localparam int XFER_POS_W = $clog2(MAX_XFERS);
    localparam int ADDR_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0]        NL_CODE      = 8'h0A;
    localparam logic [ADDR_W-1:0] LINE2_ADDR   = 7'h40;
    localparam logic [7:0]        SET_ADDR_CMD = 8'h80;
    localparam logic [7:0]        CLEAR_CMD    = 8'h01;
    localparam logic [7:0]        NIBBLE_MASK  = 8'hF0;
    localparam logic [15:0]       NIBBLE_WAIT  = 16'd1;

    localparam logic [15:0] GENERAL_WAIT_RESET = 16'd100;
    localparam logic [15:0] CLEAR_WAIT_RESET   = 16'd2000;

    localparam logic [CFG_IDX_W-1:0] CFG_EIGHT_BIT_BUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GENERAL_WAIT_US = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_WAIT_US   = 2'd2;

    localparam logic MODE_BEGIN = 1'b0;
    localparam logic RS_INSTR   = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic        reg_select;
        logic [7:0]  bus_value;
        logic [15:0] wait_us;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic        eight_bit_bus;
        logic [15:0] general_wait_us;
        logic [15:0] clear_wait_us;
    } cfg_t;

    typedef struct packed {
        logic [XFER_CNT_W-1:0]          count;
        out_item_t [MAX_XFERS-1:0]      xfers;
    } xfer_set_t;

endpackage

[rtl/lcd2_cfg.sv]
// configuration registers of the lcd character writer
// depends on lcd2_pkg
module lcd2_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lcd2_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lcd2_pkg::CFG_DATA_W-1:0] cfg_data,
    output lcd2_pkg::cfg_t                 cfg
);
    import lcd2_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.eight_bit_bus   <= 1'b0;
            cfg_reg.general_wait_us <= GENERAL_WAIT_RESET;
            cfg_reg.clear_wait_us   <= CLEAR_WAIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EIGHT_BIT_BUS:   cfg_reg.eight_bit_bus   <= cfg_data[0];
                CFG_GENERAL_WAIT_US: cfg_reg.general_wait_us <= cfg_data;
                CFG_CLEAR_WAIT_US:   cfg_reg.clear_wait_us   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/lcd2_seq.sv]
// position state and transfer list generation for one item
// depends on lcd2_pkg
module lcd2_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  lcd2_pkg::in_item_t  item,
    input  lcd2_pkg::cfg_t      cfg,
    output lcd2_pkg::xfer_set_t xfer_set
);
    import lcd2_pkg::*;

    logic [CHAR_IDX_W-1:0] char_index_reg, char_index_next;
    logic [ADDR_W-1:0]     ddram_address_reg, ddram_address_next;
    logic                  stopped_reg, stopped_next;

    logic [1:0]      nbytes;
    logic [7:0]      byte_val [2];
    logic            byte_rs  [2];
    logic [15:0]     byte_wait [2];
    logic            is_nl;
    logic            line1;
    logic            wrap;
    logic [ADDR_W-1:0] addr_use;

    assign is_nl = (item.char_code == NL_CODE);
    assign line1 = (char_index_reg < CHAR_IDX_W'(LINE_CHARS));
    assign wrap  = (char_index_reg == CHAR_IDX_W'(LINE_CHARS))
                   && (ddram_address_reg < LINE2_ADDR);
    assign addr_use = wrap ? LINE2_ADDR : ddram_address_reg;

    // byte level decisions
    always_comb
    begin
        char_index_next    = char_index_reg;
        ddram_address_next = ddram_address_reg;
        stopped_next       = stopped_reg;
        nbytes             = 2'd0;
        byte_val[0]  = CLEAR_CMD;
        byte_rs[0]   = RS_INSTR;
        byte_wait[0] = cfg.clear_wait_us;
        byte_val[1]  = item.char_code;
        byte_rs[1]   = RS_DATA;
        byte_wait[1] = cfg.general_wait_us;
        if (item.mode == MODE_BEGIN)
        begin
            char_index_next    = '0;
            ddram_address_next = '0;
            stopped_next       = 1'b0;
            nbytes             = 2'd1;
        end
        else if (stopped_reg || (char_index_reg >= CHAR_IDX_W'(MAX_CHARS)))
        begin
            nbytes = 2'd0;
        end
        else if (is_nl && line1)
        begin
            ddram_address_next = LINE2_ADDR;
            char_index_next    = char_index_reg + 1'b1;
        end
        else if (!wrap && is_nl)
        begin
            stopped_next = 1'b1;
        end
        else
        begin
            nbytes             = 2'd2;
            byte_val[0]        = SET_ADDR_CMD | {1'b0, addr_use};
            byte_wait[0]       = cfg.general_wait_us;
            ddram_address_next = addr_use + 1'b1;
            char_index_next    = char_index_reg + 1'b1;
        end
    end

    // bytes to bus transfers
    always_comb
    begin
        xfer_set.xfers = '0;
        if (cfg.eight_bit_bus)
        begin
            xfer_set.count = XFER_CNT_W'(nbytes);
            for (int k = 0; k < 2; k++)
            begin
                xfer_set.xfers[k].reg_select = byte_rs[k];
                xfer_set.xfers[k].bus_value  = byte_val[k];
                xfer_set.xfers[k].wait_us    = byte_wait[k];
                xfer_set.xfers[k].last       = (2'(k + 1) == nbytes);
            end
        end
        else
        begin
            xfer_set.count = XFER_CNT_W'({nbytes, 1'b0});
            for (int k = 0; k < 2; k++)
            begin
                xfer_set.xfers[2*k].reg_select   = byte_rs[k];
                xfer_set.xfers[2*k].bus_value    = byte_val[k] & NIBBLE_MASK;
                xfer_set.xfers[2*k].wait_us      = NIBBLE_WAIT;
                xfer_set.xfers[2*k].last         = 1'b0;
                xfer_set.xfers[2*k+1].reg_select = byte_rs[k];
                xfer_set.xfers[2*k+1].bus_value  = {byte_val[k][3:0], 4'b0000};
                xfer_set.xfers[2*k+1].wait_us    = byte_wait[k];
                xfer_set.xfers[2*k+1].last       = (2'(k + 1) == nbytes);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_index_reg    <= '0;
            ddram_address_reg <= '0;
            stopped_reg       <= 1'b0;
        end
        else if (load)
        begin
            char_index_reg    <= char_index_next;
            ddram_address_reg <= ddram_address_next;
            stopped_reg       <= stopped_next;
        end
    end

endmodule

[rtl/lcd2_obuf.sv]
// result buffer holding the transfers of one item, sent one per cycle while xfer_stall is low
// depends on lcd2_pkg
module lcd2_obuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  lcd2_pkg::xfer_set_t xfer_set,
    output logic                free,
    output logic                xfer_valid,
    input  logic                xfer_stall,
    output lcd2_pkg::out_item_t xfer
);
    import lcd2_pkg::*;

    out_item_t [MAX_XFERS-1:0] xfers_reg;
    logic [XFER_CNT_W-1:0]     remain_reg;
    logic [XFER_POS_W-1:0]     pos_reg;
    logic                      take;

    assign xfer_valid = (remain_reg != '0);
    assign take       = xfer_valid && !xfer_stall;
    assign free       = (remain_reg == '0) || (take && (remain_reg == XFER_CNT_W'(1)));
    assign xfer       = xfers_reg[pos_reg];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            xfers_reg <= xfer_set.xfers;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= '0;
            pos_reg    <= '0;
        end
        else if (load)
        begin
            remain_reg <= xfer_set.count;
            pos_reg    <= '0;
        end
        else if (take)
        begin
            remain_reg <= remain_reg - 1'b1;
            pos_reg    <= pos_reg + 1'b1;
        end
    end

endmodule

[rtl/lcd_two_line_char_writer.sv]
// Two-line, 16-column character LCD writer: each item is registered, turned into
// up to four bus transfers in one pass and then sent one transfer per cycle, while
// xfer_stall is low, from the result buffer. One item can wait in the input register
// while the buffer drains. An item yields 1 transfer for begin in 8-bit mode, 2 for a
// character in 8-bit mode or begin in 4-bit mode and 4 for a character in 4-bit mode;
// items that cause no transfer are still registered and loaded.
// depends on lcd2_pkg, lcd2_cfg, lcd2_seq, lcd2_obuf
module lcd_two_line_char_writer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  lcd2_pkg::in_item_t              item,
    output logic                            xfer_valid,
    input  logic                            xfer_stall,
    output lcd2_pkg::out_item_t             xfer,
    input  logic                            cfg_we,
    input  logic [lcd2_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lcd2_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lcd2_pkg::*;

    in_item_t  item_reg;
    logic      item_valid_reg;
    logic      free;
    logic      load;
    cfg_t      cfg;
    xfer_set_t xfer_set;

    assign load       = item_valid_reg && free;
    assign item_stall = item_valid_reg && !free;

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_valid && !item_stall)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (load)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    lcd2_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lcd2_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .item     (item_reg),
        .cfg      (cfg),
        .xfer_set (xfer_set)
    );

    lcd2_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .xfer_set   (xfer_set),
        .free       (free),
        .xfer_valid (xfer_valid),
        .xfer_stall (xfer_stall),
        .xfer       (xfer)
    );

endmodule
